// ===== src/buddy_free_coalesce_macros.svh =====
// Assertion macros for the buddy free-list keeper.
// Define ASSERT_OFF to compile the checks away.
`ifndef BUDDY_FREE_COALESCE_MACROS_SVH
`define BUDDY_FREE_COALESCE_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

// ===== src/bfc_pkg.sv =====
// Shared types and codes for the buddy free-list keeper.
// No dependencies.
package bfc_pkg;
    localparam logic [1:0] ACT_LOAD    = 2'd0;
    localparam logic [1:0] ACT_RELEASE = 2'd1;
    localparam logic [1:0] ACT_READ    = 2'd2;
    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_FULL     = 2'd1;
    localparam logic [1:0] ST_TOP      = 2'd2;

    typedef struct packed {
        logic latch;      // capture input beat
        logic mem_rd;     // capture RAM data into hold register
        logic scan_clr;   // index to zero
        logic scan_inc;   // advance index
        logic shift_wr;   // write shifted entry
        logic ins_wr;     // write inserted entry
        logic app_wr;     // append at count
        logic cnt_inc;
        logic cnt_dec;
        logic merge;      // addr bit k clear, k+1
        logic done;       // emit result
        logic [1:0] st;   // status to report
    } t_cmd;

    typedef struct packed {
        logic match;      // RAM data equals buddy
        logic greater;    // RAM data above addr
        logic at_end;     // index reached count
        logic cnt_full;
        logic ord_bad;
        logic no_buddy;   // k beyond address bits
        logic top;        // k+1 beyond top order
        logic [1:0] act;
        logic idx_ok;
    } t_stat;
endpackage

// ===== src/bfc_ram.sv =====
// Generic single-port-write, one-read RAM with registered read.
// No dependencies.
module bfc_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end
    assign o_rdata = r_rdata;
endmodule

// ===== src/bfc_dp.sv =====
// Datapath: input registers, list counts, free-list RAM, scan index, result.
// Depends on bfc_pkg and bfc_ram.
module bfc_dp
    import bfc_pkg::*;
#(
    parameter int NUM_ORDERS = 16,
    parameter int LIST_DEPTH = 16,
    parameter int ADDR_BITS  = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_cmd        i_cmd,
    output t_stat       o_stat,
    input  logic [1:0]  i_action,
    input  logic [3:0]  i_order,
    input  logic [15:0] i_block_addr,
    input  logic [3:0]  i_entry_index,
    output logic        o_done,
    output logic [1:0]  o_status,
    output logic [3:0]  o_final_order,
    output logic [15:0] o_final_addr,
    output logic        o_read_valid,
    output logic [15:0] o_read_addr
);
    localparam int OW = (NUM_ORDERS > 1) ? $clog2(NUM_ORDERS) : 1;
    localparam int IW = $clog2(LIST_DEPTH);
    localparam int CW = $clog2(LIST_DEPTH + 1);
    localparam int KW = 6;

    logic [1:0]  r_act;
    logic [KW-1:0] r_k;
    logic [15:0] r_a;
    logic [3:0]  r_idx;
    logic [CW-1:0] r_cnt [NUM_ORDERS];
    logic [IW:0] r_i;
    logic [15:0] r_hold;   // entry displaced during insert
    logic [15:0] rdata;
    logic [OW-1:0] k_o;
    logic [CW-1:0] cnt_k;
    logic [15:0] bit_k;
    logic        we;
    logic [IW-1:0] widx, ridx;
    logic [15:0] wdata;
    logic [15:0] amask;

    assign k_o   = r_k[OW-1:0];
    assign cnt_k = r_k < KW'(NUM_ORDERS) ? r_cnt[k_o] : '0;
    assign bit_k = (r_k < 6'd16) ? (16'd1 << r_k[3:0]) : 16'd0;
    assign amask = (ADDR_BITS >= 16) ? 16'hFFFF : 16'((32'd1 << ADDR_BITS) - 1);

    bfc_ram #(.WIDTH(16), .DEPTH(NUM_ORDERS * LIST_DEPTH)) u_ram (
        .i_clk(i_clk), .i_we(we),
        .i_waddr({k_o, widx}), .i_wdata(wdata),
        .i_raddr({k_o, ridx}), .o_rdata(rdata)
    );
    // shift_wr on drop: write rdata (entry i) to i-1; ins_wr: write carried address to i
    assign we    = i_cmd.shift_wr | i_cmd.ins_wr | i_cmd.app_wr;
    assign ridx  = (r_act == ACT_READ) ? IW'(r_idx) : r_i[IW-1:0];
    always_comb begin
        widx  = r_i[IW-1:0];
        wdata = r_a;
        if (i_cmd.app_wr) begin
            widx = cnt_k[IW-1:0];
        end else if (i_cmd.shift_wr) begin
            widx  = IW'(r_i - 1'b1);
            wdata = rdata;
        end
    end

    assign o_stat.match    = rdata == (r_a ^ bit_k);
    assign o_stat.greater  = rdata > r_a;
    assign o_stat.at_end   = r_i >= (IW + 1)'(cnt_k);
    assign o_stat.cnt_full = cnt_k >= CW'(LIST_DEPTH);
    assign o_stat.ord_bad  = r_k >= KW'(NUM_ORDERS);
    assign o_stat.no_buddy = r_k >= KW'(ADDR_BITS);
    assign o_stat.top      = (r_k + KW'(1)) >= KW'(NUM_ORDERS);
    assign o_stat.act      = r_act;
    assign o_stat.idx_ok   = !o_stat.ord_bad && ({{CW{1'b0}}, r_idx} < {4'd0, cnt_k});

    always_ff @(posedge i_clk) begin
        if (i_cmd.latch) begin
            r_act <= i_action;
            r_k   <= KW'(i_order);
            r_a   <= i_block_addr & amask;
            r_idx <= i_entry_index;
        end
        if (i_cmd.merge) begin
            r_a <= r_a & ~bit_k;
            r_k <= r_k + 1'b1;
        end
        if (i_cmd.mem_rd) begin
            r_hold <= rdata;
        end
        if (i_cmd.ins_wr) begin
            r_a <= r_hold;  // carry displaced entry for tail of insert
        end
        if (i_cmd.scan_clr) begin
            r_i <= '0;
        end else if (i_cmd.scan_inc) begin
            r_i <= r_i + 1'b1;
        end
    end

    logic r_done;
    logic [1:0]  r_status;
    logic [3:0]  r_fo;
    logic [15:0] r_fa, r_ra;
    logic        r_rv;
    logic [15:0] r_final;  // address as first inserted
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int o = 0; o < NUM_ORDERS; o++) begin
                r_cnt[o] <= '0;
            end
            r_done <= 1'b0;
        end else begin
            r_done <= i_cmd.done;
            if (i_cmd.cnt_inc) begin
                r_cnt[k_o] <= cnt_k + 1'b1;
            end else if (i_cmd.cnt_dec) begin
                r_cnt[k_o] <= cnt_k - 1'b1;
            end
        end
        if (i_cmd.latch || i_cmd.merge) begin
            r_final <= i_cmd.latch ? (i_block_addr & amask) : (r_a & ~bit_k);
        end
        if (i_cmd.done) begin
            r_status <= i_cmd.st;
            r_fo <= '0; r_fa <= '0; r_rv <= 1'b0; r_ra <= '0;
            if (r_act == ACT_READ) begin
                r_rv <= o_stat.idx_ok;
                r_ra <= o_stat.idx_ok ? rdata : 16'd0;
            end else if ((r_act == ACT_LOAD || r_act == ACT_RELEASE) && !o_stat.ord_bad) begin
                r_fo <= r_k[3:0];
                r_fa <= r_final;
            end
        end
    end
    assign o_done        = r_done;
    assign o_status      = r_status;
    assign o_final_order = r_fo;
    assign o_final_addr  = r_fa;
    assign o_read_valid  = r_rv;
    assign o_read_addr   = r_ra;
endmodule

// ===== src/bfc_ctrl.sv =====
// Controller: sequences load, release search/drop/merge/insert, and read.
// Depends on bfc_pkg.
module bfc_ctrl
    import bfc_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_start,
    output logic  o_busy,
    input  t_stat i_stat,
    output t_cmd  o_cmd
);
    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_DISP  = 4'd1;
    localparam logic [3:0] S_SRD   = 4'd2;
    localparam logic [3:0] S_SCHK  = 4'd3;
    localparam logic [3:0] S_DRD   = 4'd4;
    localparam logic [3:0] S_DWR   = 4'd5;
    localparam logic [3:0] S_IRD   = 4'd6;
    localparam logic [3:0] S_ICHK  = 4'd7;
    localparam logic [3:0] S_TRD   = 4'd8;
    localparam logic [3:0] S_TWR   = 4'd9;
    localparam logic [3:0] S_RRD   = 4'd10;
    localparam logic [3:0] S_RWT   = 4'd11;
    localparam logic [3:0] S_DONE  = 4'd12;
    localparam logic [3:0] S_ICHK2 = 4'd13;

    logic [3:0] r_state, n_state;
    logic [1:0] r_st, n_st;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_st    <= ST_OK;
        end else begin
            r_state <= n_state;
            r_st    <= n_st;
        end
    end
    assign o_busy = r_state != S_IDLE;

    always_comb begin
        n_state = r_state;
        n_st    = r_st;
        o_cmd   = '0;
        o_cmd.st = r_st;
        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    o_cmd.latch    = 1'b1;
                    o_cmd.scan_clr = 1'b1;
                    n_st    = ST_OK;
                    n_state = S_DISP;
                end
            end
            S_DISP: begin
                priority if (i_stat.act == ACT_READ) begin
                    n_state = S_RRD;
                end else if (i_stat.act == ACT_LOAD || i_stat.act == ACT_RELEASE) begin
                    if (i_stat.ord_bad) begin
                        n_st = ST_TOP; n_state = S_DONE;
                    end else if (i_stat.act == ACT_LOAD) begin
                        if (i_stat.cnt_full) begin
                            n_st = ST_FULL;
                        end else begin
                            o_cmd.app_wr = 1'b1; o_cmd.cnt_inc = 1'b1;
                        end
                        n_state = S_DONE;
                    end else if (i_stat.no_buddy) begin
                        o_cmd.scan_clr = 1'b1; n_state = S_IRD;
                    end else begin
                        o_cmd.scan_clr = 1'b1; n_state = S_SRD;
                    end
                end else begin
                    n_state = S_DONE;
                end
            end
            S_SRD: begin
                if (i_stat.at_end) begin
                    o_cmd.scan_clr = 1'b1; n_state = S_IRD;
                end else begin
                    n_state = S_SCHK;
                end
            end
            S_SCHK: begin
                if (i_stat.match) begin
                    if (i_stat.top) begin
                        n_st = ST_TOP; o_cmd.scan_clr = 1'b1; n_state = S_IRD;
                    end else begin
                        o_cmd.scan_inc = 1'b1; n_state = S_DRD;
                    end
                end else begin
                    o_cmd.scan_inc = 1'b1; n_state = S_SRD;
                end
            end
            S_DRD: begin
                if (i_stat.at_end) begin
                    o_cmd.cnt_dec = 1'b1; o_cmd.merge = 1'b1; o_cmd.scan_clr = 1'b1;
                    n_state = S_DISP;
                end else begin
                    n_state = S_DWR;
                end
            end
            S_DWR: begin
                o_cmd.shift_wr = 1'b1; o_cmd.scan_inc = 1'b1; n_state = S_DRD;
            end
            S_IRD: begin
                if (i_stat.cnt_full) begin
                    n_st = ST_FULL; n_state = S_DONE;
                end else if (i_stat.at_end) begin
                    o_cmd.app_wr = 1'b1; o_cmd.cnt_inc = 1'b1; n_state = S_DONE;
                end else begin
                    n_state = S_ICHK;
                end
            end
            S_ICHK: begin
                if (i_stat.greater) begin
                    o_cmd.mem_rd = 1'b1; n_state = S_TWR;
                end else begin
                    o_cmd.scan_inc = 1'b1; n_state = S_IRD;
                end
            end
            S_TWR: begin
                // place carried address at index, pick up displaced entry
                o_cmd.ins_wr = 1'b1; o_cmd.scan_inc = 1'b1; n_state = S_TRD;
            end
            S_TRD: begin
                if (i_stat.at_end) begin
                    o_cmd.app_wr = 1'b1; o_cmd.cnt_inc = 1'b1; n_state = S_DONE;
                end else begin
                    n_state = S_ICHK2;
                end
            end
            S_ICHK2: begin
                o_cmd.mem_rd = 1'b1; n_state = S_TWR;
            end
            S_RWT: begin
                o_cmd.done = 1'b1; n_state = S_IDLE;
            end
            S_RRD: begin
                n_state = S_RWT;
            end
            S_DONE: begin
                o_cmd.done = 1'b1; n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end
endmodule

// ===== src/buddy_free_coalesce.sv =====
// Top level of the buddy free-list keeper.
// Depends on bfc_pkg, bfc_ctrl, bfc_dp and the assertion macro header.
`include "buddy_free_coalesce_macros.svh"
// Usage:
//   Raise start with an action beat (load, release, read) while busy is low.
//   The beat is taken at that edge and busy is high from the next cycle on.
//   One result beat per action appears on the o_ result ports for one cycle,
//   marked by o_done; the receiver cannot stall it. For a load or an unused
//   action the controller goes from dispatch to its done state; a read
//   passes a RAM read state, then a wait state that issues the result.
//   Busy stays high until the controller is idle again; beats never overlap.
//   Release scans the order's list for the buddy, reading and checking each
//   entry; on a match it shifts the tail down one entry at a time and
//   repeats one order up with the merged address. The final sorted insert
//   walks to its place and then moves the tail up by carrying each displaced
//   entry. Every step goes through the free-list RAM, so release time grows
//   with the list lengths and the number of merges.
//   Reset clears the per-order counts and the controller; the store itself
//   is not cleared, entries above a count are never used.
module buddy_free_coalesce
    import bfc_pkg::*;
#(
    parameter int NUM_ORDERS = 16,
    parameter int LIST_DEPTH = 16,
    parameter int ADDR_BITS  = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  i_action,
    input  logic [3:0]  i_order,
    input  logic [15:0] i_block_addr,
    input  logic [3:0]  i_entry_index,
    output logic        o_done,
    output logic [1:0]  o_status,
    output logic [3:0]  o_final_order,
    output logic [15:0] o_final_addr,
    output logic        o_read_valid,
    output logic [15:0] o_read_addr
);
    t_cmd  cmd;
    t_stat stat;

    bfc_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(start), .o_busy(busy),
        .i_stat(stat), .o_cmd(cmd)
    );
    bfc_dp #(.NUM_ORDERS(NUM_ORDERS), .LIST_DEPTH(LIST_DEPTH), .ADDR_BITS(ADDR_BITS)) u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cmd(cmd), .o_stat(stat),
        .i_action(i_action), .i_order(i_order), .i_block_addr(i_block_addr),
        .i_entry_index(i_entry_index), .o_done(o_done), .o_status(o_status),
        .o_final_order(o_final_order), .o_final_addr(o_final_addr),
        .o_read_valid(o_read_valid), .o_read_addr(o_read_addr)
    );

    `ASSERT_NEXT(a_done_pulse, i_clk, i_rst_n, o_done, !o_done)
    `ASSERT_IMPL(a_done_while_idle, i_clk, i_rst_n, o_done, !busy)
    `ASSERT_IMPL(a_read_fields, i_clk, i_rst_n, o_done && !o_read_valid, o_read_addr == 16'd0)
endmodule

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 1ps
// Testbench for buddy_free_coalesce: directed table, then random beats of every action.
// Result beats are checked against typed rows or the in-bench model. Depends on bfc_pkg.
module testbench;
    import bfc_pkg::*;

    localparam int ORDERS = 16;
    localparam int DEPTH = 16;
    localparam logic [1:0] ACT_NONE = 2'd3;
    localparam int CYCLE_LIMIT = 3000000;

    typedef struct packed {
        logic [1:0]  status;
        logic [3:0]  fin_order;
        logic [15:0] fin_addr;
        logic        rd_valid;
        logic [15:0] rd_addr;
    } t_outcome;

    typedef struct {
        logic [1:0]  action;
        logic [3:0]  order;
        logic [15:0] addr;
        logic [3:0]  index;
        bit          typed;
        t_outcome    want;
    } t_row;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        start = 1'b0;
    logic [1:0]  i_action = '0;
    logic [3:0]  i_order = '0;
    logic [15:0] i_block_addr = '0;
    logic [3:0]  i_entry_index = '0;
    logic        busy, o_done, o_read_valid;
    logic [1:0]  o_status;
    logic [3:0]  o_final_order;
    logic [15:0] o_final_addr, o_read_addr;

    logic [15:0] free_addr [ORDERS][DEPTH];
    int          free_cnt [ORDERS];
    t_outcome    pending_outcomes [$];
    t_row        rows [$];
    int          errors = 0;
    int          cycles = 0;
    int          n_merges = 0, n_full = 0, n_top = 0, n_releases = 0, n_beats = 0;

    buddy_free_coalesce DUT (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
        .i_action(i_action), .i_order(i_order), .i_block_addr(i_block_addr),
        .i_entry_index(i_entry_index), .o_done(o_done), .o_status(o_status),
        .o_final_order(o_final_order), .o_final_addr(o_final_addr),
        .o_read_valid(o_read_valid), .o_read_addr(o_read_addr)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    function automatic bit insert_sorted(int k, logic [15:0] a);
        int pos;
        if (free_cnt[k] >= DEPTH) return 1'b0;
        pos = 0;
        while (pos < free_cnt[k] && free_addr[k][pos] <= a) pos++;
        for (int i = free_cnt[k]; i > pos; i--) free_addr[k][i] = free_addr[k][i-1];
        free_addr[k][pos] = a;
        free_cnt[k]++;
        return 1'b1;
    endfunction

    function automatic t_outcome free_list_step(logic [1:0] act, logic [3:0] ord,
                                                logic [15:0] addr, logic [3:0] idx);
        t_outcome r;
        int k, pos;
        logic [15:0] a, bud;
        r = '0;
        k = ord;
        a = addr;
        if (act == ACT_LOAD) begin
            if (free_cnt[k] >= DEPTH) r.status = ST_FULL;
            else begin
                free_addr[k][free_cnt[k]] = a;
                free_cnt[k]++;
            end
            r.fin_order = ord;
            r.fin_addr = a;
        end else if (act == ACT_RELEASE) begin
            forever begin
                bud = a ^ (16'd1 << k);
                pos = -1;
                for (int i = 0; i < free_cnt[k]; i++)
                    if (pos < 0 && free_addr[k][i] == bud) pos = i;
                if (pos < 0) break;
                if (k + 1 >= ORDERS) begin
                    r.status = ST_TOP;
                    break;
                end
                for (int i = pos; i + 1 < free_cnt[k]; i++) free_addr[k][i] = free_addr[k][i+1];
                free_cnt[k]--;
                a = a & ~(16'd1 << k);
                k++;
                n_merges++;
            end
            if (!insert_sorted(k, a)) r.status = ST_FULL;
            r.fin_order = k[3:0];
            r.fin_addr = a;
        end else if (act == ACT_READ) begin
            if (idx < free_cnt[ord]) begin
                r.rd_valid = 1'b1;
                r.rd_addr = free_addr[ord][idx];
            end
        end
        return r;
    endfunction

    function automatic void add_row(logic [1:0] act, logic [3:0] ord, logic [15:0] addr,
                                    logic [3:0] idx, bit typed, t_outcome want);
        t_row w;
        w.action = act; w.order = ord; w.addr = addr; w.index = idx;
        w.typed = typed; w.want = want;
        rows.push_back(w);
    endfunction

    task automatic issue_beat(t_row w, bit idle_on);
        t_outcome p;
        int gap;
        gap = idle_on ? int'($urandom_range(0, 19)) : 0;
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start <= 1'b1;
        i_action <= w.action;
        i_order <= w.order;
        i_block_addr <= w.addr;
        i_entry_index <= w.index;
        do @(posedge i_clk); while (busy);
        p = free_list_step(w.action, w.order, w.addr, w.index);
        if (w.action == ACT_RELEASE) n_releases++;
        pending_outcomes.push_back(w.typed ? w.want : p);
    endtask

    always @(posedge i_clk) begin
        t_outcome e;
        if (i_rst_n && o_done) begin
            n_beats++;
            if (o_status == ST_FULL) n_full++;
            if (o_status == ST_TOP) n_top++;
            if (pending_outcomes.size() == 0) begin
                $error("result beat with nothing expected");
                errors++;
            end else begin
                e = pending_outcomes.pop_front();
                if (o_status !== e.status) begin
                    $error("status: expected %0d, actual %0d", e.status, o_status); errors++;
                end
                if (o_final_order !== e.fin_order) begin
                    $error("final_order: expected %0d, actual %0d", e.fin_order, o_final_order);
                    errors++;
                end
                if (o_final_addr !== e.fin_addr) begin
                    $error("final_addr: expected %h, actual %h", e.fin_addr, o_final_addr);
                    errors++;
                end
                if (o_read_valid !== e.rd_valid) begin
                    $error("read_valid: expected %0d, actual %0d", e.rd_valid, o_read_valid);
                    errors++;
                end
                if (o_read_addr !== e.rd_addr) begin
                    $error("read_addr: expected %h, actual %h", e.rd_addr, o_read_addr);
                    errors++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    initial begin
        t_row w;
        int sel, k;
        bit idle_on;
        for (int i = 0; i < ORDERS; i++) free_cnt[i] = 0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        add_row(ACT_READ, 4'd0, 16'h0, 4'd0, 1, '0);
        add_row(ACT_NONE, 4'd15, 16'hFFFF, 4'd15, 1, '0);
        add_row(ACT_LOAD, 4'd0, 16'hFFFF, 4'd0, 1, '{ST_OK, 4'd0, 16'hFFFF, 1'b0, 16'h0});
        add_row(ACT_RELEASE, 4'd0, 16'hFFFE, 4'd0, 0, '0);
        add_row(ACT_READ, 4'd1, 16'h0, 4'd0, 0, '0);
        add_row(ACT_RELEASE, 4'd15, 16'h0000, 4'd0, 1, '{ST_OK, 4'd15, 16'h0, 1'b0, 16'h0});
        add_row(ACT_RELEASE, 4'd15, 16'h8000, 4'd0, 1, '{ST_TOP, 4'd15, 16'h8000, 1'b0, 16'h0});
        add_row(ACT_READ, 4'd15, 16'h0, 4'd1, 0, '0);
        add_row(ACT_RELEASE, 4'd3, 16'h0008, 4'd0, 0, '0);
        add_row(ACT_RELEASE, 4'd3, 16'h0000, 4'd0, 0, '0);
        add_row(ACT_READ, 4'd4, 16'h0, 4'd0, 0, '0);
        add_row(ACT_RELEASE, 4'd5, 16'h1234, 4'd0, 0, '0);
        add_row(ACT_RELEASE, 4'd5, 16'h1214, 4'd0, 0, '0);
        for (int i = 0; i < DEPTH; i++) add_row(ACT_LOAD, 4'd14, 16'(i * 3 + 1), 4'd0, 0, '0);
        add_row(ACT_LOAD, 4'd14, 16'h5555, 4'd0, 1, '{ST_FULL, 4'd14, 16'h5555, 1'b0, 16'h0});
        add_row(ACT_READ, 4'd14, 16'h0, 4'd15, 0, '0);
        add_row(ACT_READ, 4'd14, 16'h0, 4'd0, 0, '0);
        foreach (rows[i]) issue_beat(rows[i], 1'b0);

        idle_on = 1'b1;
        for (int n = 0; n < 1100; n++) begin
            if (n % 100 == 0) idle_on = !idle_on;
            sel = $urandom_range(0, 99);
            k = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 15) : $urandom_range(0, 5);
            w.order = k[3:0];
            w.index = 4'($urandom_range(0, 15));
            w.typed = 0;
            w.want = '0;
            if ($urandom_range(0, 9) == 0) w.addr = 16'($urandom_range(0, 16'hFFFF));
            else w.addr = 16'(($urandom_range(0, 15) << k) | ($urandom_range(0, 3) << 12));
            if (sel < 50) w.action = ACT_RELEASE;
            else if (sel < 62) w.action = ACT_LOAD;
            else if (sel < 95) w.action = ACT_READ;
            else w.action = ACT_NONE;
            issue_beat(w, idle_on);
        end
        start <= 1'b0;

        while (pending_outcomes.size() != 0) @(posedge i_clk);
        repeat (200) @(posedge i_clk);
        $display("Covered %0d result beats, %0d releases with %0d merges.",
                 n_beats, n_releases, n_merges);
        $display("Status full seen %0d times, merge beyond top seen %0d times.", n_full, n_top);
        if (errors == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end
endmodule
